// ===== design/dhcpopt_pkg.sv =====
// dhcpopt_pkg: types, codes and the option class table of the dhcp option parser
// no dependencies
package dhcpopt_pkg;

  // parse phases
  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // special option codes
  localparam logic [7:0] CODE_PAD = 8'd0;
  localparam logic [7:0] CODE_END = 8'd255;

  // result kinds
  localparam logic [2:0] KIND_VALUE = 3'd0;
  localparam logic [2:0] KIND_EMPTY = 3'd1;
  localparam logic [2:0] KIND_END   = 3'd2;
  localparam logic [2:0] KIND_TRUNC = 3'd3;
  localparam logic [2:0] KIND_NOEND = 3'd4;

  // option classes
  localparam logic [2:0] CLS_GENERIC = 3'd0;
  localparam logic [2:0] CLS_IP      = 3'd1;
  localparam logic [2:0] CLS_TEXT    = 3'd2;
  localparam logic [2:0] CLS_IP_LIST = 3'd3;
  localparam logic [2:0] CLS_SHORT   = 3'd4;
  localparam logic [2:0] CLS_BYTE    = 3'd5;
  localparam logic [2:0] CLS_WORD    = 3'd6;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] code;
    logic [2:0] cls;
    logic [7:0] length;
    logic [7:0] index;
  } state_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] option_code;
    logic [2:0] option_class;
    logic [7:0] value_byte;
    logic [7:0] byte_index;
    logic       option_last;
    logic       run_last;
  } res_t;

  typedef struct packed {
    state_t          state;
    res_t [1:0]      res;
    logic [1:0]      num;
  } step_out_t;

  function automatic logic [2:0] class_of(input logic [7:0] code);
    logic [2:0] c;
    case (code)
      8'd1, 8'd3, 8'd16, 8'd28, 8'd32, 8'd50, 8'd54: c = CLS_IP;
      8'd12, 8'd14, 8'd15, 8'd17, 8'd18, 8'd40, 8'd56,
      8'd60, 8'd62, 8'd64, 8'd66, 8'd67, 8'd86, 8'd87: c = CLS_TEXT;
      8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
      8'd41, 8'd42, 8'd44, 8'd45, 8'd48, 8'd49, 8'd65,
      8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74,
      8'd75, 8'd76, 8'd85: c = CLS_IP_LIST;
      8'd13, 8'd22, 8'd26, 8'd57: c = CLS_SHORT;
      8'd19, 8'd20, 8'd23, 8'd27, 8'd29, 8'd30, 8'd31,
      8'd34, 8'd36, 8'd37, 8'd39, 8'd46, 8'd52, 8'd53: c = CLS_BYTE;
      8'd2, 8'd24, 8'd35, 8'd38, 8'd51, 8'd58, 8'd59: c = CLS_WORD;
      default: c = CLS_GENERIC;
    endcase
    return c;
  endfunction

endpackage

// ===== design/dhcpopt_in_if.sv =====
// dhcpopt_in_if: byte stream channel into the dhcp option parser
// no dependencies
interface dhcpopt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// ===== design/dhcpopt_out_if.sv =====
// dhcpopt_out_if: result channel out of the dhcp option parser
// no dependencies
interface dhcpopt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] option_code;
  logic [2:0] option_class;
  logic [7:0] value_byte;
  logic [7:0] byte_index;
  logic       option_last;
  logic       run_last;

  modport source (output valid, output result_kind, output option_code,
                  output option_class, output value_byte, output byte_index,
                  output option_last, output run_last, input ready);
  modport sink   (input valid, input result_kind, input option_code,
                  input option_class, input value_byte, input byte_index,
                  input option_last, input run_last, output ready);
endinterface

// ===== design/dhcpopt_step.sv =====
// dhcpopt_step: next parse state and up to two results for one option byte
// depends on dhcpopt_pkg
module dhcpopt_step import dhcpopt_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_last_i,
  output step_out_t  step_o
);

  state_t     st;
  res_t       r0;
  res_t       r1;
  logic [1:0] n;
  logic       bnd;
  logic       olast;
  logic [7:0] idx_inc;

  assign idx_inc = state_i.index + 8'd1;
  assign olast   = (idx_inc == state_i.length);

  always_comb begin
    st  = state_i;
    r0  = '0;
    r1  = '0;
    n   = 2'd0;
    bnd = 1'b0;
    case (state_i.phase)
      PH_CODE: begin
        if (data_byte_i == CODE_PAD) begin
          bnd = 1'b1;
        end else if (data_byte_i == CODE_END) begin
          r0.result_kind = KIND_END;
          r0.option_code = CODE_END;
          n        = 2'd1;
          st.phase = PH_DONE;
        end else begin
          st.code   = data_byte_i;
          st.cls    = class_of(data_byte_i);
          st.length = 8'd0;
          st.index  = 8'd0;
          st.phase  = PH_LEN;
          if (frame_last_i) begin
            r0.result_kind  = KIND_TRUNC;
            r0.option_code  = data_byte_i;
            r0.option_class = class_of(data_byte_i);
            n = 2'd1;
          end
        end
      end
      PH_LEN: begin
        st.length = data_byte_i;
        st.index  = 8'd0;
        r0.option_code  = state_i.code;
        r0.option_class = state_i.cls;
        if (data_byte_i == 8'd0) begin
          r0.result_kind = KIND_EMPTY;
          n        = 2'd1;
          st.phase = PH_CODE;
          bnd      = 1'b1;
        end else begin
          st.phase = PH_VAL;
          if (frame_last_i) begin
            r0.result_kind = KIND_TRUNC;
            n = 2'd1;
          end
        end
      end
      PH_VAL: begin
        r0.result_kind  = KIND_VALUE;
        r0.option_code  = state_i.code;
        r0.option_class = state_i.cls;
        r0.value_byte   = data_byte_i;
        r0.byte_index   = state_i.index;
        r0.option_last  = olast;
        n        = 2'd1;
        st.index = idx_inc;
        if (olast) begin
          st.phase = PH_CODE;
          bnd      = 1'b1;
        end else if (frame_last_i) begin
          r1.result_kind  = KIND_TRUNC;
          r1.option_code  = state_i.code;
          r1.option_class = state_i.cls;
          r1.byte_index   = idx_inc;
          n = 2'd2;
        end
      end
      default: begin
      end
    endcase

    if (frame_last_i) begin
      if (bnd) begin
        // missing end marker goes after whatever the byte produced
        if (n == 2'd0) begin
          r0 = '0;
          r0.result_kind = KIND_NOEND;
        end else begin
          r1 = '0;
          r1.result_kind = KIND_NOEND;
        end
        n = n + 2'd1;
      end
      st.phase = PH_CODE;
    end

    if (n == 2'd1) begin
      r0.run_last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.run_last = 1'b1;
    end
  end

  assign step_o.state  = st;
  assign step_o.res[0] = r0;
  assign step_o.res[1] = r1;
  assign step_o.num    = n;

endmodule

// ===== design/dhcp_option_tlv_parser_core.sv =====
// dhcp_option_tlv_parser_core: top level of the dhcp option area parser
// depends on dhcpopt_pkg, dhcpopt_in_if, dhcpopt_out_if and dhcpopt_step
// output: each result is registered in the result queue and shown from its head
// throughput: one byte per cycle while bytes give at most one result each and out_o
//   is ready; two results of one byte leave one at a time by the single result port
// buffering: four-entry result queue, a byte is taken while at least two entries are free
// reset: asynchronous, parser returns to expect code and the queue empties
module dhcp_option_tlv_parser_core import dhcpopt_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  dhcpopt_in_if.sink     in_i,
  dhcpopt_out_if.source  out_o
);

  localparam int unsigned QDEPTH = 4;

  // parse state
  state_t    st_q;
  step_out_t step;

  // result queue
  res_t       q_mem [QDEPTH];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       in_acc;
  logic       out_acc;
  logic [2:0] push_n;
  res_t       head;

  dhcpopt_step u_step (
    .state_i      (st_q),
    .data_byte_i  (in_i.data_byte),
    .frame_last_i (in_i.frame_last),
    .step_o       (step)
  );

  // room for the worst case of two results per byte
  assign in_i.ready = (cnt_q <= 3'd2);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign push_n     = in_acc ? {1'b0, step.num} : 3'd0;

  assign wr_d  = wr_q + push_n[1:0];
  assign rd_d  = rd_q + {1'b0, out_acc};
  assign cnt_d = cnt_q + push_n - {2'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) begin
        st_q <= step.state;
      end
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // payload storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc && step.num != 2'd0) begin
      q_mem[wr_q] <= step.res[0];
    end
    if (in_acc && step.num == 2'd2) begin
      q_mem[wr_q + 2'd1] <= step.res[1];
    end
  end

  assign head = q_mem[rd_q];

  assign out_o.valid        = (cnt_q != 3'd0);
  assign out_o.result_kind  = head.result_kind;
  assign out_o.option_code  = head.option_code;
  assign out_o.option_class = head.option_class;
  assign out_o.value_byte   = head.value_byte;
  assign out_o.byte_index   = head.byte_index;
  assign out_o.option_last  = head.option_last;
  assign out_o.run_last     = head.run_last;

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDEPTH))
    else $error("result queue overfilled");

  // a frame mark always sends the parser back to expect code
  a_frame_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.frame_last |=> st_q.phase == PH_CODE)
    else $error("phase not reset at frame end");

  // after the end code, bytes of the same frame are ignored
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.frame_last && st_q.phase == PH_DONE |=> st_q.phase == PH_DONE)
    else $error("left done phase inside a frame");

  // a missing end marker is always the final result of its byte
  a_noend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == KIND_NOEND |-> out_o.run_last)
    else $error("no end marker not last of run");
`endif

endmodule
